/* hdl/scg_pkg.sv */
// Package for the sphere contact generator: pipeline stage map, item context
// type, opcodes and the fixed-point helper functions used by the datapath.
// No dependencies.
package scg_pkg;

	// Stream widths: payload fields packed from bit 0, padded to whole bytes.
	localparam int IN_DATA_W  = 272;
	localparam int OUT_DATA_W = 240;

	// One root bit per square root stage, one quotient bit per divider stage.
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 32;

	// Stage map of the pipeline.
	localparam int ST_SQ    = 3;
	localparam int ST_PLANE = ST_SQ + 1;
	localparam int ST_HIT   = ST_SQ + SQRT_STEPS + 1;
	localparam int ST_NRM   = ST_HIT + DIV_STEPS + 1;
	localparam int ST_MUL   = ST_NRM + 1;
	localparam int ST_OUT   = ST_MUL + 1;

	localparam logic [31:0] S32_MAX_V = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN_V = 32'h8000_0000;

	typedef enum logic {
		OP_SPHERE = 1'b0,
		OP_PLANE  = 1'b1
	} op_t;

	// Per-item context that travels with the valid bit.
	// nv holds the center difference (sphere) or the negated plane normal,
	// and later the contact normal.
	typedef struct packed {
		op_t              op;
		logic [15:0]      tag;
		logic [2:0][31:0] c;
		logic [2:0][31:0] nv;
		logic [30:0]      radius;
		logic [31:0]      other;
		logic             hit;
		logic [30:0]      depth;
		logic [31:0]      cdist;
		logic [2:0]       ovf;
	} ctx_t;

	// Result register contents.
	typedef struct packed {
		logic             hit;
		logic             pvalid;
		logic [2:0][31:0] nrm;
		logic [30:0]      depth;
		logic [2:0][31:0] pt;
		logic [15:0]      tag;
	} res_t;

	// Clamp a wide signed value to 32-bit signed.
	function automatic logic [31:0] sat32(input logic signed [51:0] v);
		logic [31:0] r;
		if (v > 52'sd2147483647)
			r = S32_MAX_V;
		else if (v < -52'sd2147483648)
			r = S32_MIN_V;
		else
			r = v[31:0];
		return r;
	endfunction

	// Clamp a wide signed value to the unsigned 31-bit depth range.
	function automatic logic [30:0] sat_depth(input logic signed [51:0] v);
		logic [30:0] r;
		if (v > 52'sd2147483647)
			r = '1;
		else if (v < 52'sd0)
			r = '0;
		else
			r = v[30:0];
		return r;
	endfunction

	// Drop 16 fraction bits, rounding toward zero.
	function automatic logic signed [47:0] drop16(input logic signed [63:0] v);
		logic signed [63:0] b;
		b = v + (v[63] ? 64'sd65535 : 64'sd0);
		return b[63:16];
	endfunction

endpackage

/* hdl/sphere_contact_generator.sv */
// Sphere contact generator top level: a fully pipelined sphere-sphere and
// sphere-plane contact test in signed Q16.16. Depends on scg_pkg.
//
//  channel | direction | tdata (low bit first)                          | tuser
//  s_*     | in        | cx cy cz sx sy sz own_radius other_value tag   | opcode
//  m_*     | out       | nx ny nz depth px py pz tag_out                | hit, point_valid
//
// One transaction enters per cycle while no result waits at the output. The
// pipeline holds the 32-stage square root (one root bit per stage) and the
// 32-stage divider (one quotient bit per stage, three components in parallel).
// Reset clears only the valid bits. When a result waits at the output the
// whole pipeline holds, so nothing is lost or repeated.
module sphere_contact_generator import scg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// cx, cy, cz, sx, sy, sz, own_radius, other_value, pair_tag, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// normal_x, normal_y, normal_z, depth, point_x, point_y, point_z, tag_out, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// hit, point_valid
	output logic [1:0]            m_tuser
);

	logic              adv;
	logic [ST_OUT:1]   vld_s;
	ctx_t              ctx_s [1:ST_MUL];
	ctx_t              ctx_nx [1:ST_MUL];
	ctx_t              ctx_in;
	logic [2:0][63:0]  prod_in;
	logic [2:0][63:0]  prod_s1;
	logic [2:0][63:0]  sqr_s2;
	logic [2:0][47:0]  trunc_s2;
	logic [63:0]       sq_s3;
	logic [51:0]       pdist_s3;
	logic              pl_hit;
	logic [30:0]       pl_depth;
	logic [33:0]       rt_rem_s  [1:SQRT_STEPS];
	logic [31:0]       rt_root_s [1:SQRT_STEPS];
	logic [63:0]       rt_val_s  [1:SQRT_STEPS];
	logic [33:0]       rt_rem_nx [1:SQRT_STEPS];
	logic [31:0]       rt_root_nx[1:SQRT_STEPS];
	logic [63:0]       rt_val_nx [1:SQRT_STEPS];
	ctx_t              hit_nx;
	logic [2:0][47:0]  num_nx;
	logic [2:0][47:0]  dv_rem_s  [0:DIV_STEPS];
	logic [2:0][31:0]  dv_q_s    [1:DIV_STEPS];
	logic [2:0][47:0]  dv_rem_nx [1:DIV_STEPS];
	logic [2:0][31:0]  dv_q_nx   [1:DIV_STEPS];
	logic [2:0][31:0]  nrm_nx;
	logic [2:0][63:0]  mprod_s70;
	res_t              res_nx;
	res_t              res_s71;

	// The pipeline moves as one unit whenever the output is free or taken.
	assign adv      = !vld_s[ST_OUT] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_s[ST_OUT];

	// Input unpacking, center differences or negated plane normal, plane products.
	always_comb begin
		logic [31:0] sv;
		ctx_in        = '0;
		ctx_in.op     = op_t'(s_tuser[0]);
		ctx_in.radius = s_tdata[222:192];
		ctx_in.other  = s_tdata[254:223];
		ctx_in.tag    = s_tdata[270:255];
		for (int i = 0; i < 3; i++) begin
			ctx_in.c[i] = s_tdata[32*i +: 32];
			sv          = s_tdata[96 + 32*i +: 32];
			if (ctx_in.op == OP_PLANE)
				ctx_in.nv[i] = sat32(52'sd0 - 52'($signed(sv)));
			else
				ctx_in.nv[i] = sat32(52'($signed(sv)) - 52'($signed(ctx_in.c[i])));
			prod_in[i] = 64'($signed(ctx_in.c[i]) * $signed(sv));
		end
	end

	// Plane test on the summed, truncated dot product.
	always_comb begin
		logic signed [51:0] rad;
		rad      = 52'($signed({1'b0, ctx_s[ST_SQ].radius}));
		pl_hit   = $signed(pdist_s3) < rad;
		pl_depth = sat_depth(rad - $signed(pdist_s3));
	end

	// Square root: one restoring step per stage, two radicand bits each.
	always_comb begin
		logic [33:0] prem;
		logic [31:0] proot;
		logic [63:0] pval;
		logic [35:0] sh;
		logic [35:0] trial;
		for (int j = 1; j <= SQRT_STEPS; j++) begin
			if (j == 1) begin
				prem  = '0;
				proot = '0;
				pval  = sq_s3;
			end else begin
				prem  = rt_rem_s[j-1];
				proot = rt_root_s[j-1];
				pval  = rt_val_s[j-1];
			end
			sh    = {prem, pval[63:62]};
			trial = {2'b00, proot, 2'b01};
			if (sh >= trial) begin
				rt_rem_nx[j]  = 34'(sh - trial);
				rt_root_nx[j] = {proot[30:0], 1'b1};
			end else begin
				rt_rem_nx[j]  = sh[33:0];
				rt_root_nx[j] = {proot[30:0], 1'b0};
			end
			rt_val_nx[j] = {pval[61:0], 2'b00};
		end
	end

	// Sphere overlap test, depth and divider setup.
	always_comb begin
		logic signed [51:0] reach;
		logic signed [51:0] distw;
		logic [31:0]        mag;
		logic [31:0]        root;
		hit_nx = ctx_s[ST_HIT-1];
		root   = rt_root_s[SQRT_STEPS];
		reach  = 52'($signed({1'b0, hit_nx.radius})) + 52'($signed(hit_nx.other));
		distw  = 52'($signed({1'b0, root}));
		hit_nx.cdist = root;
		if (hit_nx.op == OP_SPHERE) begin
			hit_nx.hit   = distw < reach;
			hit_nx.depth = sat_depth(reach - distw);
		end
		for (int i = 0; i < 3; i++) begin
			mag            = hit_nx.nv[i][31] ? 32'(~hit_nx.nv[i] + 32'd1) : hit_nx.nv[i];
			num_nx[i]      = {mag, 16'h0000};
			hit_nx.ovf[i]  = {16'h0000, mag} >= {root, 16'h0000};
		end
	end

	// Divider: one quotient bit per stage for all three components.
	always_comb begin
		logic [2:0][47:0] prem;
		logic [2:0][31:0] pq;
		logic [63:0]      dsh;
		for (int j = 1; j <= DIV_STEPS; j++) begin
			prem = dv_rem_s[j-1];
			if (j == 1)
				pq = '0;
			else
				pq = dv_q_s[j-1];
			dsh  = {32'h0, ctx_s[ST_HIT+j-1].cdist} << (DIV_STEPS - j);
			for (int i = 0; i < 3; i++) begin
				if ({16'h0000, prem[i]} >= dsh) begin
					dv_rem_nx[j][i] = 48'({16'h0000, prem[i]} - dsh);
					dv_q_nx[j][i]   = {pq[i][30:0], 1'b1};
				end else begin
					dv_rem_nx[j][i] = prem[i];
					dv_q_nx[j][i]   = {pq[i][30:0], 1'b0};
				end
			end
		end
	end

	// Signed, saturated unit normal; zero when the centers coincide.
	always_comb begin
		logic [31:0] q;
		for (int i = 0; i < 3; i++) begin
			q = dv_q_s[DIV_STEPS][i];
			if (ctx_s[ST_NRM-1].cdist == 32'h0)
				nrm_nx[i] = '0;
			else if (ctx_s[ST_NRM-1].nv[i][31]) begin
				if (ctx_s[ST_NRM-1].ovf[i] || q > S32_MIN_V)
					nrm_nx[i] = S32_MIN_V;
				else
					nrm_nx[i] = 32'(~q + 32'd1);
			end else begin
				if (ctx_s[ST_NRM-1].ovf[i] || q[31])
					nrm_nx[i] = S32_MAX_V;
				else
					nrm_nx[i] = q;
			end
		end
	end

	// Next context per stage; some stages fill in the results computed there.
	always_comb begin
		ctx_nx[1] = ctx_in;
		for (int k = 2; k <= ST_MUL; k++)
			ctx_nx[k] = ctx_s[k-1];
		ctx_nx[ST_PLANE].hit   = pl_hit;
		ctx_nx[ST_PLANE].depth = pl_depth;
		ctx_nx[ST_HIT]         = hit_nx;
		if (ctx_s[ST_NRM-1].op == OP_SPHERE)
			ctx_nx[ST_NRM].nv = nrm_nx;
	end

	// Contact point and final result selection.
	always_comb begin
		res_nx       = '0;
		res_nx.tag   = ctx_s[ST_MUL].tag;
		if (ctx_s[ST_MUL].hit) begin
			res_nx.hit   = 1'b1;
			res_nx.nrm   = ctx_s[ST_MUL].nv;
			res_nx.depth = ctx_s[ST_MUL].depth;
			if (ctx_s[ST_MUL].op == OP_SPHERE) begin
				res_nx.pvalid = 1'b1;
				for (int i = 0; i < 3; i++)
					res_nx.pt[i] = sat32(52'($signed(ctx_s[ST_MUL].c[i]))
						+ 52'(drop16($signed(mprod_s70[i]))));
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[ST_OUT-1:1], s_tvalid};
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= ST_MUL; k++)
				ctx_s[k] <= ctx_nx[k];
			prod_s1  <= prod_in;

			for (int i = 0; i < 3; i++) begin
				sqr_s2[i]   <= 64'($signed(ctx_s[1].nv[i]) * $signed(ctx_s[1].nv[i]));
				trunc_s2[i] <= drop16($signed(prod_s1[i]));
			end
			sq_s3    <= sqr_s2[0] + sqr_s2[1] + sqr_s2[2];
			pdist_s3 <= 52'($signed(trunc_s2[0])) + 52'($signed(trunc_s2[1]))
				+ 52'($signed(trunc_s2[2])) - 52'($signed(ctx_s[2].other));

			for (int j = 1; j <= SQRT_STEPS; j++) begin
				rt_rem_s[j]  <= rt_rem_nx[j];
				rt_root_s[j] <= rt_root_nx[j];
				rt_val_s[j]  <= rt_val_nx[j];
			end

			dv_rem_s[0]   <= num_nx;
			for (int j = 1; j <= DIV_STEPS; j++) begin
				dv_rem_s[j] <= dv_rem_nx[j];
				dv_q_s[j]   <= dv_q_nx[j];
			end

			for (int i = 0; i < 3; i++)
				mprod_s70[i] <= 64'($signed(ctx_s[ST_NRM].nv[i])
					* $signed({1'b0, ctx_s[ST_NRM].radius}));

			res_s71 <= res_nx;
		end
	end

	// Output packing.
	assign m_tuser = {res_s71.pvalid, res_s71.hit};
	assign m_tdata = {1'b0, res_s71.tag, res_s71.pt[2], res_s71.pt[1], res_s71.pt[0],
		res_s71.depth, res_s71.nrm[2], res_s71.nrm[1], res_s71.nrm[0]};

endmodule

/* hdl/scg_checker.sv */
// Port-level checker for the sphere contact generator, bound to the top level.
// Depends on the top level's port list only.
module scg_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [271:0] s_tdata,
	input logic [0:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [239:0] m_tdata,
	input logic [1:0]   m_tuser
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction dropped while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// With nothing at the output the input side is always open.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output");

	// A miss carries only the tag.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !m_tuser[1] && m_tdata[222:0] == '0)
		else $error("miss result carries nonzero contact fields");

	// A contact point exists only with a hit.
	a_point_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("contact point flagged without a hit");

endmodule

bind sphere_contact_generator scg_checker u_scg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
